[design/gvbd_pkg.sv]
// shared constants and controller/datapath interface types for the gamma block decoder
package gvbd_pkg;

    // fixed word width of the compressed stream and of decoded values
    localparam int WORD_BITS     = 32;
    // default number of interleaved lanes per block
    localparam int LANES_DEFAULT = 16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_sel;   // accepted item is a selector word
        logic load_lane;  // accepted item is a lane word
        logic step;       // extract one row into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic want_sel;   // next accepted item is taken as a selector
        logic sel_zero;   // current selector has no rows
        logic last_row;   // row under extraction is the last of the lane word
        logic out_free;   // output register can take a new item this cycle
    } t_dp_stat;

endpackage

[design/gvbd_ctrl.sv]
// controller state machine: sequences selector loads, lane loads and row walks
module gvbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    output gvbd_pkg::t_dp_cmd  o_cmd,
    input  gvbd_pkg::t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;

    // next state and command decode
    always_comb begin
        n_state        = r_state;
        s_axis_tready  = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (i_stat.want_sel) begin
                        o_cmd.load_sel = 1'b1;
                    end else begin
                        o_cmd.load_lane = 1'b1;
                        if (!i_stat.sel_zero) begin
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.last_row) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a lane word with rows always starts a walk
    a_lane_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_lane && !i_stat.sel_zero |=> r_state == S_WALK)
        else $error("lane word with rows did not start a walk");

    // the last row of a walk returns the controller to accepting items
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step && i_stat.last_row |=> r_state == S_IDLE)
        else $error("walk did not end after its last row");

endmodule

[design/gvbd_datapath.sv]
// datapath: selector, lane carries, row extraction, position counters, output register
module gvbd_datapath #(
    parameter int LANES = gvbd_pkg::LANES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [gvbd_pkg::WORD_BITS-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*gvbd_pkg::WORD_BITS-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    input  gvbd_pkg::t_dp_cmd                 i_cmd,
    output gvbd_pkg::t_dp_stat                o_stat
);

    localparam int WB    = gvbd_pkg::WORD_BITS;
    localparam int BW    = $clog2(WB);
    localparam int LW    = $clog2(LANES);
    localparam int WW    = $clog2(LANES + 1);
    localparam int ADV_W = $clog2(WB * LANES + 1);

    // block state
    logic [WW-1:0]    r_wib;
    logic [WB-1:0]    r_sel;
    logic [WB-1:0]    r_carry [LANES];
    logic [WB-1:0]    r_base_pos;
    logic [ADV_W-1:0] r_blk_adv;

    // lane walk state
    logic [WB-1:0]    r_word;
    logic [WB-1:0]    r_rem;
    logic [BW:0]      r_prev;
    logic             r_first;
    logic [WB-1:0]    r_pos;

    // output register
    logic             r_out_valid;
    logic [WB-1:0]    r_out_value;
    logic [WB-1:0]    r_out_pos;
    logic             r_out_last;

    logic [LW-1:0]    c_lane;
    logic [BW-1:0]    c_bit;
    logic [BW:0]      c_end;
    logic [BW:0]      c_width;
    logic [WB-1:0]    c_mask;
    logic [WB-1:0]    c_value;
    logic [WB-1:0]    c_rest;
    logic             c_last;
    logic             c_lane_done;
    logic [WB-1:0]    n_carry;

    assign c_lane = LW'(r_wib - 1'b1);

    // lowest pending selector bit ends the current row
    always_comb begin
        c_bit = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                c_bit = BW'(i);
            end
        end
    end

    // row extraction: bits between the previous row end and this one
    assign c_end   = {1'b0, c_bit} + 1'b1;
    assign c_width = c_end - r_prev;
    assign c_mask  = {WB{1'b1}} >> (BW'(WB - 1) - c_bit);
    assign c_value = ((r_word & c_mask) >> r_prev)
                   | (r_first ? (r_carry[c_lane] << c_width) : '0);
    assign c_rest  = r_rem & (r_rem - 1'b1);
    assign c_last  = (c_rest == '0);

    // new carry: whole word for an empty selector, else bits above the last row
    assign n_carry     = i_cmd.load_lane ? s_axis_tdata : (r_word >> c_end);
    assign c_lane_done = (i_cmd.load_lane && o_stat.sel_zero) || (i_cmd.step && c_last);

    // status to the controller
    assign o_stat.want_sel = s_axis_tuser || (r_wib == '0);
    assign o_stat.sel_zero = (r_sel == '0);
    assign o_stat.last_row = c_last;
    assign o_stat.out_free = !r_out_valid || m_axis_tready;

    // block counters, carries and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wib       <= '0;
            r_sel       <= '0;
            r_base_pos  <= '0;
            r_blk_adv   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_carry[i] <= '0;
            end
        end else begin
            if (i_cmd.load_sel) begin
                r_sel     <= s_axis_tdata;
                r_wib     <= WW'(1);
                r_blk_adv <= '0;
                if (s_axis_tuser) begin
                    r_base_pos <= '0;
                    for (int i = 0; i < LANES; i++) begin
                        r_carry[i] <= '0;
                    end
                end
            end
            // rows of the block are counted while the first lane is walked
            if (i_cmd.step && r_wib == WW'(1)) begin
                r_blk_adv <= r_blk_adv + ADV_W'(LANES);
            end
            if (c_lane_done) begin
                r_carry[c_lane] <= n_carry;
                if (r_wib == WW'(LANES)) begin
                    r_wib      <= '0;
                    r_base_pos <= r_base_pos + WB'(r_blk_adv);
                end else begin
                    r_wib <= r_wib + 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // lane walk and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_lane) begin
            r_word  <= s_axis_tdata;
            r_rem   <= r_sel;
            r_prev  <= '0;
            r_first <= 1'b1;
            r_pos   <= r_base_pos + WB'(c_lane);
        end
        if (i_cmd.step) begin
            r_rem       <= c_rest;
            r_prev      <= c_end;
            r_first     <= 1'b0;
            r_pos       <= r_pos + WB'(LANES);
            r_out_value <= c_value;
            r_out_pos   <= r_pos;
            r_out_last  <= c_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pos, r_out_value};
    assign m_axis_tlast  = r_out_last;

    // a row is only extracted while selector bits remain
    a_step_has_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_rem != '0)
        else $error("row extraction with no selector bits left");

    // the block position never passes the last lane
    a_wib_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wib <= WW'(LANES))
        else $error("block position beyond last lane");

endmodule

[design/gamma_vertical_block_decoder_top.sv]
// Vertical Elias-gamma block decoder: one stream word per input item, one value per output item.
// A selector word is only loaded. A lane word is loaded, then walked one selector row (1 to 32)
// per cycle through the single row-extraction unit while the output register is free; no new
// item is accepted during a walk. A zero selector makes a lane word a load only, with no rows.
// i_rst_n is synchronous, active low: clears lane carries, block counters, row base and
// output valid; the next item is taken as a selector.
module gamma_vertical_block_decoder_top #(
    parameter int LANES = gvbd_pkg::LANES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gvbd_pkg::WORD_BITS-1:0]    s_axis_tdata,   // [31:0] stream_word
    input  logic                              s_axis_tuser,   // [0] new_list
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*gvbd_pkg::WORD_BITS-1:0]  m_axis_tdata,   // [31:0] decoded_value, [63:32] position
    output logic                              m_axis_tlast    // run_end
);

    gvbd_pkg::t_dp_cmd  w_cmd;
    gvbd_pkg::t_dp_stat w_stat;

    // sequencing
    gvbd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .o_cmd         (w_cmd),
        .i_stat        (w_stat)
    );

    // decode datapath
    gvbd_datapath #(
        .LANES (LANES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat)
    );

endmodule
